>>> rtl/core/olem_pkg.sv
// shared types, constants and default parameters of the output level exposure meter
package olem_pkg;

    // default sizes
    localparam int DEF_HISTORY_DEPTH = 1024;
    localparam int DEF_PEAK_WINDOW   = 64;
    localparam int DEF_SHORT_WINDOW  = 256;
    localparam int DEF_LONG_WINDOW   = 768;

    // serial divider widths
    localparam int NUM_W = 48;
    localparam int DEN_W = 16;
    localparam int QCNT_W = 6;

    // levels in Q4.12
    localparam logic [15:0] UNITY_Q        = 16'd4096;
    localparam logic [15:0] LEVEL_HALF     = 16'd2048;
    localparam logic [15:0] LEVEL_3Q       = 16'd3072;
    localparam logic [15:0] LEVEL_NINETY   = 16'd3687;
    localparam logic [15:0] LEVEL_NEAR     = 16'd4015;
    localparam logic [15:0] STEP_LIMIT     = 16'd32768;

    // operation selects
    localparam logic [2:0] OP_SLEW  = 3'd0;
    localparam logic [2:0] OP_SHORT = 3'd1;
    localparam logic [2:0] OP_LONG  = 3'd2;
    localparam logic [2:0] OP_HALF  = 3'd3;
    localparam logic [2:0] OP_3Q    = 3'd4;
    localparam logic [2:0] OP_NINE  = 3'd5;
    localparam logic [2:0] OP_NEAR  = 3'd6;

    // root selects
    localparam logic [2:0] RT_SHORT = 3'd0;
    localparam logic [2:0] RT_LONG  = 3'd1;

    typedef struct packed {
        logic signed [15:0] drive_sample;
        logic signed [15:0] composer_sample;
        logic [15:0]        time_step;
    } t_in_item;

    typedef struct packed {
        logic [15:0] magnitude;
        logic [12:0] headroom;
        logic        over_unity;
        logic        near_limit;
        logic [31:0] slew_rate;
        logic [15:0] recent_peak;
        logic [15:0] rms_short;
        logic [15:0] rms_long;
        logic [16:0] share_half;
        logic [16:0] share_three_quarter;
        logic [16:0] share_ninety;
        logic [16:0] share_near_limit;
    } t_out_item;

    typedef struct packed {
        logic       load;
        logic       sweep;
        logic       div_start;
        logic       sqrt_start;
        logic       publish;
        logic [2:0] idx;
    } t_cmd;

    typedef struct packed {
        logic sweep_last;
        logic div_done;
        logic sqrt_done;
        logic out_free;
    } t_stat;

endpackage

>>> rtl/core/olem_div.sv
// restoring divider, one quotient bit per cycle
module olem_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [olem_pkg::NUM_W-1:0] i_num,
    input  logic [olem_pkg::DEN_W-1:0] i_den,
    output logic                       o_done,
    output logic [olem_pkg::NUM_W-1:0] o_quo
);
    logic [olem_pkg::DEN_W-1:0]  r_den;
    logic [olem_pkg::DEN_W-1:0]  r_rem;
    logic [olem_pkg::NUM_W-1:0]  r_quo;
    logic [olem_pkg::QCNT_W-1:0] r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [olem_pkg::DEN_W:0]    trial;
    logic                        fits;

    // trial subtract
    assign trial = {r_rem, r_quo[olem_pkg::NUM_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= olem_pkg::QCNT_W'(olem_pkg::NUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= fits ? olem_pkg::DEN_W'(trial - {1'b0, r_den})
                          : trial[olem_pkg::DEN_W-1:0];
            r_quo <= {r_quo[olem_pkg::NUM_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

>>> rtl/core/olem_sqrt.sv
// digit-by-digit integer square root, two radicand bits per cycle
module olem_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_x,
    output logic        o_done,
    output logic [15:0] o_root
);
    logic [31:0] r_x;
    logic [17:0] r_rem;
    logic [15:0] r_root;
    logic [3:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [17:0] acc;
    logic [17:0] trial;

    // next partial remainder and trial value
    assign acc   = {r_rem[15:0], r_x[31:30]};
    assign trial = {r_root, 2'b01};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd15;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_x;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x <= {r_x[29:0], 2'b00};
            if (acc >= trial) begin
                r_rem  <= acc - trial;
                r_root <= {r_root[14:0], 1'b1};
            end else begin
                r_rem  <= acc;
                r_root <= {r_root[14:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

>>> rtl/core/olem_ctrl.sv
// sequencer: history sweep, divisions, roots and result hand-off
module olem_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  olem_pkg::t_stat i_st,
    output olem_pkg::t_cmd  o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_SWEEP, S_DRAIN, S_DIV_GO, S_DIV_WAIT, S_SQ_GO, S_SQ_WAIT, S_PUB
    } t_state;

    t_state     r_state;
    logic [2:0] r_idx;

    // state and operation index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_SWEEP;
                end
                S_SWEEP: begin
                    if (i_st.sweep_last) r_state <= S_DRAIN;
                end
                S_DRAIN: begin
                    r_idx   <= olem_pkg::OP_SLEW;
                    r_state <= S_DIV_GO;
                end
                S_DIV_GO: r_state <= S_DIV_WAIT;
                S_DIV_WAIT: begin
                    if (i_st.div_done) begin
                        if (r_idx == olem_pkg::OP_NEAR) begin
                            r_idx   <= olem_pkg::RT_SHORT;
                            r_state <= S_SQ_GO;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_DIV_GO;
                        end
                    end
                end
                S_SQ_GO: r_state <= S_SQ_WAIT;
                S_SQ_WAIT: begin
                    if (i_st.sqrt_done) begin
                        if (r_idx == olem_pkg::RT_LONG) begin
                            r_state <= S_PUB;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_SQ_GO;
                        end
                    end
                end
                S_PUB: begin
                    if (i_st.out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // command decode
    assign o_in_ready       = (r_state == S_IDLE);
    assign o_cmd.load       = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.sweep      = (r_state == S_SWEEP);
    assign o_cmd.div_start  = (r_state == S_DIV_GO);
    assign o_cmd.sqrt_start = (r_state == S_SQ_GO);
    assign o_cmd.publish    = (r_state == S_PUB) && i_st.out_free;
    assign o_cmd.idx        = r_idx;

`ifndef SYNTH
    a_div_done_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_st.div_done |-> r_state == S_DIV_WAIT) else $error("divider done out of turn");
    a_sqrt_done_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_st.sqrt_done |-> r_state == S_SQ_WAIT) else $error("root done out of turn");
    a_last_div_to_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_WAIT && i_st.div_done && r_idx == olem_pkg::OP_NEAR)
        |=> r_state == S_SQ_GO) else $error("roots not started after divisions");
    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_SWEEP) else $error("item accepted outside idle");
`endif
endmodule

>>> rtl/core/olem_dp.sv
// datapath: history ring, sweep accumulators, shared divider and root unit, output register
module olem_dp #(
    parameter int HISTORY_DEPTH = olem_pkg::DEF_HISTORY_DEPTH,
    parameter int PEAK_WINDOW   = olem_pkg::DEF_PEAK_WINDOW,
    parameter int SHORT_WINDOW  = olem_pkg::DEF_SHORT_WINDOW,
    parameter int LONG_WINDOW   = olem_pkg::DEF_LONG_WINDOW
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  olem_pkg::t_in_item  i_in_item,
    input  olem_pkg::t_cmd      i_cmd,
    output olem_pkg::t_stat     o_st,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output olem_pkg::t_out_item o_out_item
);
    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int NW = olem_pkg::NUM_W;

    logic [15:0] mem [HISTORY_DEPTH];

    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt, r_age, r_rd_age;
    logic [15:0]   r_prev, r_rd;
    logic          r_have, r_rd_valid;
    logic [15:0]   r_mag, r_ad, r_step;
    logic [12:0]   r_head;
    logic          r_over, r_near, r_slew_ok;
    logic [15:0]   r_peak;
    logic [NW-1:0] r_sum_s, r_sum_l;
    logic [CW-1:0] r_c0, r_c1, r_c2, r_c3;
    logic [31:0]   r_slew, r_q_s, r_q_l;
    logic [16:0]   r_sh0, r_sh1, r_sh2, r_sh3;
    logic [15:0]   r_rms_s, r_rms_l;
    logic          r_ovalid;
    olem_pkg::t_out_item r_out;

    logic [15:0]   mag, cmag;
    logic [16:0]   sd;
    logic [CW-1:0] n_cnt, n_s, n_l;
    logic [31:0]   sq;
    logic [NW-1:0] div_num, div_quo;
    logic [olem_pkg::DEN_W-1:0] div_den;
    logic          div_done, sqrt_done;
    logic [15:0]   root;

    // input magnitudes and slew difference
    assign mag  = i_in_item.drive_sample[15] ? 16'(~i_in_item.drive_sample + 16'd1)
                                             : i_in_item.drive_sample;
    assign cmag = i_in_item.composer_sample[15] ? 16'(~i_in_item.composer_sample + 16'd1)
                                                : i_in_item.composer_sample;
    assign sd   = {i_in_item.drive_sample[15], i_in_item.drive_sample} - {r_prev[15], r_prev};
    assign n_cnt = (32'(r_cnt) < HISTORY_DEPTH) ? r_cnt + 1'b1 : r_cnt;

    // window lengths
    assign n_s = (32'(r_cnt) < SHORT_WINDOW) ? r_cnt : CW'(SHORT_WINDOW);
    assign n_l = (32'(r_cnt) < LONG_WINDOW)  ? r_cnt : CW'(LONG_WINDOW);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp       <= '0;
            r_cnt      <= '0;
            r_prev     <= '0;
            r_have     <= 1'b0;
            r_rd_valid <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.sweep;
            if (i_cmd.load) begin
                r_wp   <= (32'(r_wp) == HISTORY_DEPTH - 1) ? '0 : r_wp + 1'b1;
                r_cnt  <= n_cnt;
                r_prev <= i_in_item.drive_sample;
                r_have <= 1'b1;
            end
            if (i_cmd.publish) r_ovalid <= 1'b1;
            else if (i_out_ready) r_ovalid <= 1'b0;
        end
    end

    // history write and sweep read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) mem[r_wp] <= mag;
        if (i_cmd.sweep) r_rd <= mem[r_rp];
    end

    // item capture and sweep address
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag     <= mag;
            r_head    <= (mag >= olem_pkg::UNITY_Q) ? 13'd0 : 13'(olem_pkg::UNITY_Q - mag);
            r_over    <= cmag > olem_pkg::UNITY_Q;
            r_near    <= mag >= olem_pkg::LEVEL_NEAR;
            r_ad      <= sd[16] ? 16'(~sd + 17'd1) : sd[15:0];
            r_step    <= i_in_item.time_step;
            r_slew_ok <= r_have && (i_in_item.time_step != '0)
                         && (i_in_item.time_step <= olem_pkg::STEP_LIMIT);
            r_rp      <= r_wp;
            r_age     <= '0;
        end else if (i_cmd.sweep) begin
            r_rp     <= (r_rp == '0) ? AW'(HISTORY_DEPTH - 1) : r_rp - 1'b1;
            r_age    <= r_age + 1'b1;
            r_rd_age <= r_age;
        end
    end

    assign sq = r_rd * r_rd;

    // sweep accumulators
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_peak  <= '0;
            r_sum_s <= '0;
            r_sum_l <= '0;
            r_c0    <= '0;
            r_c1    <= '0;
            r_c2    <= '0;
            r_c3    <= '0;
        end else if (r_rd_valid) begin
            if (32'(r_rd_age) < PEAK_WINDOW && r_rd > r_peak) r_peak <= r_rd;
            if (32'(r_rd_age) < SHORT_WINDOW) r_sum_s <= r_sum_s + NW'(sq);
            if (32'(r_rd_age) < LONG_WINDOW)  r_sum_l <= r_sum_l + NW'(sq);
            r_c0 <= r_c0 + CW'(r_rd >= olem_pkg::LEVEL_HALF);
            r_c1 <= r_c1 + CW'(r_rd >= olem_pkg::LEVEL_3Q);
            r_c2 <= r_c2 + CW'(r_rd >= olem_pkg::LEVEL_NINETY);
            r_c3 <= r_c3 + CW'(r_rd >= olem_pkg::LEVEL_NEAR);
        end
    end

    // divider operand select
    always_comb begin
        div_num = '0;
        div_den = olem_pkg::DEN_W'(r_cnt);
        case (i_cmd.idx)
            olem_pkg::OP_SLEW: begin
                div_num = NW'(r_ad) << 16;
                div_den = r_step;
            end
            olem_pkg::OP_SHORT: begin
                div_num = r_sum_s;
                div_den = olem_pkg::DEN_W'(n_s);
            end
            olem_pkg::OP_LONG: begin
                div_num = r_sum_l;
                div_den = olem_pkg::DEN_W'(n_l);
            end
            olem_pkg::OP_HALF: div_num = NW'(r_c0) << 16;
            olem_pkg::OP_3Q:   div_num = NW'(r_c1) << 16;
            olem_pkg::OP_NINE: div_num = NW'(r_c2) << 16;
            olem_pkg::OP_NEAR: div_num = NW'(r_c3) << 16;
            default: div_num = '0;
        endcase
    end

    olem_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    olem_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_x     ((i_cmd.idx == olem_pkg::RT_SHORT) ? r_q_s : r_q_l),
        .o_done  (sqrt_done),
        .o_root  (root)
    );

    // quotient and root capture
    always_ff @(posedge i_clk) begin
        if (div_done) begin
            case (i_cmd.idx)
                olem_pkg::OP_SLEW:
                    r_slew <= !r_slew_ok ? 32'd0 :
                              (|div_quo[NW-1:32]) ? 32'hFFFF_FFFF : div_quo[31:0];
                olem_pkg::OP_SHORT: r_q_s <= div_quo[31:0];
                olem_pkg::OP_LONG:  r_q_l <= div_quo[31:0];
                olem_pkg::OP_HALF:  r_sh0 <= div_quo[16:0];
                olem_pkg::OP_3Q:    r_sh1 <= div_quo[16:0];
                olem_pkg::OP_NINE:  r_sh2 <= div_quo[16:0];
                olem_pkg::OP_NEAR:  r_sh3 <= div_quo[16:0];
                default: r_slew <= r_slew;
            endcase
        end
        if (sqrt_done) begin
            if (i_cmd.idx == olem_pkg::RT_SHORT) r_rms_s <= root;
            else r_rms_l <= root;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out.magnitude           <= r_mag;
            r_out.headroom            <= r_head;
            r_out.over_unity          <= r_over;
            r_out.near_limit          <= r_near;
            r_out.slew_rate           <= r_slew;
            r_out.recent_peak         <= r_peak;
            r_out.rms_short           <= r_rms_s;
            r_out.rms_long            <= r_rms_l;
            r_out.share_half          <= r_sh0;
            r_out.share_three_quarter <= r_sh1;
            r_out.share_ninety        <= r_sh2;
            r_out.share_near_limit    <= r_sh3;
        end
    end

    assign o_st.sweep_last = (r_age + CW'(1)) == r_cnt;
    assign o_st.div_done   = div_done;
    assign o_st.sqrt_done  = sqrt_done;
    assign o_st.out_free   = !r_ovalid || i_out_ready;
    assign o_out_valid     = r_ovalid;
    assign o_out_item      = r_out;

`ifndef SYNTH
    a_publish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.publish |-> (!r_ovalid || i_out_ready)) else $error("result overwritten");
    a_sweep_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sweep |-> r_age < r_cnt) else $error("sweep past stored history");
    a_cnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> r_cnt != '0) else $error("division by empty history");
`endif
endmodule

>>> rtl/core/output_level_exposure_meter_core.sv
// top level of the output level exposure meter
// Each accepted item stores the drive sample magnitude in the history ring and yields one
// result item. Per item, all n stored magnitudes (n up to HISTORY_DEPTH) are swept one
// entry per cycle through the single read port of the ring, then seven divisions run one
// bit per cycle on a shared 48-bit divider and two square roots on a two-bit-per-cycle root
// unit. A finished result waits in an output register while the next item is accepted.
// The ring needs no clearing pass after reset: only written entries are ever read.
module output_level_exposure_meter_core #(
    parameter int HISTORY_DEPTH = olem_pkg::DEF_HISTORY_DEPTH,
    parameter int PEAK_WINDOW   = olem_pkg::DEF_PEAK_WINDOW,
    parameter int SHORT_WINDOW  = olem_pkg::DEF_SHORT_WINDOW,
    parameter int LONG_WINDOW   = olem_pkg::DEF_LONG_WINDOW
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  olem_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output olem_pkg::t_out_item o_out_item
);
    olem_pkg::t_cmd  cmd;
    olem_pkg::t_stat st;

    // sequencer
    olem_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    // datapath
    olem_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .PEAK_WINDOW   (PEAK_WINDOW),
        .SHORT_WINDOW  (SHORT_WINDOW),
        .LONG_WINDOW   (LONG_WINDOW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_st        (st),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );
endmodule

>>> tb/olem_checker.sv
// checker for the level meter: watches both channels, predicts each result and compares
module olem_checker #(
    parameter int HISTORY_DEPTH = olem_pkg::DEF_HISTORY_DEPTH,
    parameter int PEAK_WINDOW   = olem_pkg::DEF_PEAK_WINDOW,
    parameter int SHORT_WINDOW  = olem_pkg::DEF_SHORT_WINDOW,
    parameter int LONG_WINDOW   = olem_pkg::DEF_LONG_WINDOW
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  olem_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  olem_pkg::t_out_item i_out_item,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_results_seen
);
    logic [15:0]         mag_ring [HISTORY_DEPTH];
    int                  ring_pos;
    int                  ring_fill;
    logic [15:0]         last_drive;
    logic                seen_first;
    olem_pkg::t_out_item level_queue[$];

    // integer square root, floored
    function automatic logic [31:0] root_floor(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res[31:0];
    endfunction

    function automatic logic [15:0] ring_age(input int age);
        return mag_ring[(ring_pos + HISTORY_DEPTH - 1 - age) % HISTORY_DEPTH];
    endfunction

    function automatic logic [15:0] window_root(input int w);
        int          n;
        logic [63:0] sq_sum;
        n = (ring_fill < w) ? ring_fill : w;
        sq_sum = 0;
        if (n == 0) return 16'd0;
        for (int a = 0; a < n; a++) sq_sum += ring_age(a) * ring_age(a);
        return 16'(root_floor(sq_sum / n));
    endfunction

    function automatic logic [16:0] share_of(input int cnt);
        logic [63:0] num;
        num = 64'(cnt) << 16;
        return 17'(num / ring_fill);
    endfunction

    // work out the level readings for one accepted item and update the ring
    task automatic predict_levels(input olem_pkg::t_in_item it);
        olem_pkg::t_out_item r;
        int          drv, prv, cmag, mag, n, diff;
        logic [63:0] sl;
        int          c_half, c_3q, c_nine, c_near;
        logic [15:0] v, pk;
        drv  = int'(it.drive_sample);
        cmag = int'(it.composer_sample);
        cmag = cmag < 0 ? -cmag : cmag;
        mag  = drv < 0 ? -drv : drv;
        sl = 0;
        if (seen_first && it.time_step != 0 && it.time_step <= olem_pkg::STEP_LIMIT) begin
            prv  = int'($signed(last_drive));
            diff = drv - prv;
            diff = diff < 0 ? -diff : diff;
            sl = (64'(diff) << 16) / it.time_step;
            if (sl > 64'hFFFF_FFFF) sl = 64'hFFFF_FFFF;
        end
        last_drive = it.drive_sample;
        seen_first = 1'b1;
        mag_ring[ring_pos] = 16'(mag);
        ring_pos = (ring_pos + 1) % HISTORY_DEPTH;
        if (ring_fill < HISTORY_DEPTH) ring_fill++;
        n = (ring_fill < PEAK_WINDOW) ? ring_fill : PEAK_WINDOW;
        pk = 0;
        for (int a = 0; a < n; a++) if (ring_age(a) > pk) pk = ring_age(a);
        c_half = 0; c_3q = 0; c_nine = 0; c_near = 0;
        for (int a = 0; a < ring_fill; a++) begin
            v = ring_age(a);
            c_half += (v >= olem_pkg::LEVEL_HALF);
            c_3q   += (v >= olem_pkg::LEVEL_3Q);
            c_nine += (v >= olem_pkg::LEVEL_NINETY);
            c_near += (v >= olem_pkg::LEVEL_NEAR);
        end
        r.magnitude           = 16'(mag);
        r.headroom            = (mag >= 4096) ? 13'd0 : 13'(4096 - mag);
        r.over_unity          = cmag > 4096;
        r.near_limit          = mag >= int'(olem_pkg::LEVEL_NEAR);
        r.slew_rate           = sl[31:0];
        r.recent_peak         = pk;
        r.rms_short           = window_root(SHORT_WINDOW);
        r.rms_long            = window_root(LONG_WINDOW);
        r.share_half          = share_of(c_half);
        r.share_three_quarter = share_of(c_3q);
        r.share_ninety        = share_of(c_nine);
        r.share_near_limit    = share_of(c_near);
        level_queue.push_back(r);
    endtask

    task automatic compare_field(input string nm, input logic [31:0] e, input logic [31:0] a);
        if (e !== a) begin
            $display("%0t: %s expected %0d actual %0d", $time, nm, e, a);
            o_fail_count++;
        end
    endtask

    // watch both channels on every rising edge
    always @(posedge i_clk) begin
        olem_pkg::t_out_item ex;
        olem_pkg::t_out_item ac;
        if (!i_rst_n) begin
            ring_pos   = 0;
            ring_fill  = 0;
            last_drive = '0;
            seen_first = 1'b0;
            level_queue.delete();
        end else begin
            if (i_in_valid && i_in_ready) predict_levels(i_in_item);
            if (i_out_valid && i_out_ready) begin
                ac = i_out_item;
                o_results_seen++;
                if (level_queue.size() == 0) begin
                    $display("%0t: unexpected result item, actual magnitude %0d", $time,
                             ac.magnitude);
                    o_fail_count++;
                end else begin
                    ex = level_queue.pop_front();
                    compare_field("magnitude", ex.magnitude, ac.magnitude);
                    compare_field("headroom", ex.headroom, ac.headroom);
                    compare_field("over_unity", ex.over_unity, ac.over_unity);
                    compare_field("near_limit", ex.near_limit, ac.near_limit);
                    compare_field("slew_rate", ex.slew_rate, ac.slew_rate);
                    compare_field("recent_peak", ex.recent_peak, ac.recent_peak);
                    compare_field("rms_short", ex.rms_short, ac.rms_short);
                    compare_field("rms_long", ex.rms_long, ac.rms_long);
                    compare_field("share_half", ex.share_half, ac.share_half);
                    compare_field("share_three_quarter", ex.share_three_quarter,
                                  ac.share_three_quarter);
                    compare_field("share_ninety", ex.share_ninety, ac.share_ninety);
                    compare_field("share_near_limit", ex.share_near_limit,
                                  ac.share_near_limit);
                end
            end
        end
        o_pending = level_queue.size();
    end

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_results_seen = 0;
    end

endmodule

>>> tb/tb_output_level_exposure_meter_core.sv
// testbench top for the level meter: stimulus, handshake idling and verdict
module tb_output_level_exposure_meter_core;

    localparam int WATCH_LIMIT = 20000;

    logic                i_clk;
    logic                i_rst_n;
    logic                in_valid;
    logic                in_ready;
    olem_pkg::t_in_item  in_item;
    logic                out_valid;
    logic                out_ready;
    olem_pkg::t_out_item out_item;
    int                  fail_count;
    int                  pending;
    int                  results_seen;
    int                  sender_idle_pct;
    int                  receiver_stall_pct;
    int                  quiet_cycles;
    int                  items_sent;

    output_level_exposure_meter_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    olem_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_item     (in_item),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_item    (out_item),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_results_seen(results_seen)
    );

    // clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // receiver stalls at random
    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // watchdog on cycles with no item moving
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCH_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", quiet_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // offer one item, with a random gap first, and hold it until accepted
    task automatic send_sample(input logic [15:0] drv, input logic [15:0] cmp,
                               input logic [15:0] stp);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{drive_sample: drv, composer_sample: cmp, time_step: stp};
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    function automatic logic [15:0] pick_level();
        case ($urandom_range(5))
            0: return 16'($urandom_range(65535));
            1: return 16'($urandom_range(4115, 3980));
            2: return 16'(-$urandom_range(4115, 3980));
            3: return 16'($urandom_range(4096, 2000));
            4: return 16'(-$urandom_range(4096, 1900));
            default: return 16'($urandom_range(300));
        endcase
    endfunction

    function automatic logic [15:0] pick_step();
        case ($urandom_range(4))
            0: return 16'($urandom_range(65535));
            1: return 16'($urandom_range(2));
            2: return 16'($urandom_range(32769, 32767));
            default: return 16'($urandom_range(500, 1));
        endcase
    endfunction

    initial begin
        in_valid           = 1'b0;
        in_item            = '0;
        out_ready          = 1'b0;
        i_rst_n            = 1'b0;
        quiet_cycles       = 0;
        items_sent         = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: first sample, extremes, thresholds, step limits, largest slew
        send_sample(16'h8000, 16'h8000, 16'd100);
        send_sample(16'h7FFF, 16'h7FFF, 16'd1);
        send_sample(16'h8000, 16'd4096, 16'd0);
        send_sample(16'd0, 16'd4097, 16'd32768);
        send_sample(16'd4015, -16'sd4097, 16'd32769);
        send_sample(16'd4014, -16'sd4096, 16'd65535);
        send_sample(-16'sd4015, 16'd0, 16'd1);
        send_sample(16'd4096, 16'hFFFF, 16'd2);
        send_sample(16'd2048, 16'd1, 16'd7);
        send_sample(16'd2047, 16'd5, 16'd9);
        send_sample(16'd3072, 16'd5, 16'd11);
        send_sample(16'd3071, 16'd5, 16'd13);
        send_sample(16'd3687, 16'd5, 16'd15);
        send_sample(16'd3686, 16'd5, 16'd32767);
        send_sample(16'h5555, 16'hAAAA, 16'h5555);
        send_sample(16'hAAAA, 16'h5555, 16'hAAAA);
        send_sample(-16'sd1, 16'd0, 16'd1);
        send_sample(16'd1, 16'd0, 16'd1);

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            sender_idle_pct    = (ph == 1) ? 61 : (ph == 3) ? 36 : 0;
            receiver_stall_pct = (ph == 2) ? 61 : (ph == 3) ? 36 : 0;
            for (int k = 0; k < 125; k++) send_sample(pick_level(), pick_level(), pick_step());
        end
        in_valid <= 1'b0;

        // drain then a short settle
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("sent %0d items and checked %0d results across four idling phases",
                 items_sent, results_seen);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/olem_pkg.sv
rtl/core/olem_div.sv
rtl/core/olem_sqrt.sv
rtl/core/olem_ctrl.sv
rtl/core/olem_dp.sv
rtl/core/output_level_exposure_meter_core.sv
tb/olem_checker.sv
tb/tb_output_level_exposure_meter_core.sv
